// ----- src/ckx_pkg.sv -----
// ----------------------------------------------------------------------------
// ckx_pkg
// Shared types, constants and base coding for the canonical k-mer extractor.
// ----------------------------------------------------------------------------
package ckx_pkg;

    localparam int        MAX_K_DEF  = 31;
    localparam logic [4:0] KLEN_RESET = 5'd22;
    localparam int        CNT_W      = 5;
    localparam logic [CNT_W-1:0] CNT_SAT = 5'd31;

    localparam int MER_W   = 62;
    localparam int DATA_W  = 64;

    // 2-bit base codes
    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    // Broadcast control for one update of the cell row
    typedef struct packed {
        logic       first;   // clear the row before this base
        logic [1:0] code;    // forward code of the incoming base
        logic [4:0] km1;     // effective k minus one
    } ckx_ctl_t;

    // {bad, code}; anything but ACGT/acgt codes as A and sets bad
    function automatic logic [2:0] base_code(input logic [7:0] ch);
        logic [2:0] r;
        begin
            case (ch)
                8'h41, 8'h61: r = {1'b0, CODE_A};
                8'h43, 8'h63: r = {1'b0, CODE_C};
                8'h47, 8'h67: r = {1'b0, CODE_G};
                8'h54, 8'h74: r = {1'b0, CODE_T};
                default:      r = {1'b1, CODE_A};
            endcase
            return r;
        end
    endfunction

endpackage

// ----- src/ckx_cell.sv -----
// ----------------------------------------------------------------------------
// ckx_cell
// One base position of the forward and reverse-complement windows.
// ----------------------------------------------------------------------------
module ckx_cell
    import ckx_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  ckx_ctl_t   ctl,
    input  logic [1:0] fwd_in,    // forward base of position IDX-1
    input  logic [1:0] rev_in,    // reverse base of position IDX+1
    output logic [1:0] fwd_reg,
    output logic [1:0] rev_reg,
    output logic [1:0] fwd_next,
    output logic [1:0] rev_next
);

    localparam logic [4:0] POS = 5'(IDX);

    always_comb
    begin
        // forward shifts up from position 0; positions past k-1 read zero
        if (POS == 5'd0)
            fwd_next = ctl.code;
        else if (POS <= ctl.km1 && !ctl.first)
            fwd_next = fwd_in;
        else
            fwd_next = 2'b00;

        // reverse complement enters at position k-1 and shifts down
        if (POS == ctl.km1)
            rev_next = ~ctl.code;
        else if (POS < ctl.km1 && !ctl.first)
            rev_next = rev_in;
        else
            rev_next = 2'b00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 2'b00;
            rev_reg <= 2'b00;
        end
        else if (en)
        begin
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
        end
    end

endmodule

// ----- src/ckx_obuf.sv -----
// ----------------------------------------------------------------------------
// ckx_obuf
// Two-entry output buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module ckx_obuf
    import ckx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W+1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W+1:0] out_data
);

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W+1:0] out_data_reg, out_data_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [DATA_W+1:0] skid_data_reg, skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end
        else if (in_valid && in_ready)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ----- src/canonical_kmer_extractor_core.sv -----
// The k-mer of an accepted base is registered into the output register, or
//   into the skid register while the result side stalls.
// Throughput: one base per cycle while s_tready is high; the window row, fill
//   count and the 62-bit window compare all update in the accept cycle.
// s_tready drops only when both output buffer entries are occupied.
// Reset (rst_n low, async): windows, fill count and buffer cleared, k-mer length returns to 22.
// ----------------------------------------------------------------------------
// canonical_kmer_extractor_core
// Rolling 2-bit forward / reverse-complement windows kept in a row of
// per-base cells; emits the canonical (smaller) window once k bases of the
// current sequence have been taken in.
// ----------------------------------------------------------------------------
module canonical_kmer_extractor_core
    import ckx_pkg::*;
#(
    parameter int MAX_K = MAX_K_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // config: k-mer length
    input  logic              cfg_we,
    input  logic [4:0]        cfg_wdata,
    // input items
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] base_char
    input  logic [0:0]        s_tuser,   // [0] first
    // result items
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [61:0] canonical_mer, [63:62] zero
    output logic [1:0]        m_tuser    // [0] from_reverse, [1] bad_base
);

    localparam int WIN_W = 2 * MAX_K;

    // Config register
    logic [4:0] klen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            klen_reg <= KLEN_RESET;
        else if (cfg_we)
            klen_reg <= cfg_wdata;
    end

    // Effective k: zero means one, clamp to the row length
    logic [4:0] k_eff;

    always_comb
    begin
        if (klen_reg == 5'd0)
            k_eff = 5'd1;
        else if (klen_reg > 5'(MAX_K))
            k_eff = 5'(MAX_K);
        else
            k_eff = klen_reg;
    end

    // Input decode and accept
    logic       accept;
    logic [2:0] dec;
    ckx_ctl_t   ctl;

    assign accept   = s_tvalid && s_tready;
    assign dec      = base_code(s_tdata);
    assign ctl.first = s_tuser[0];
    assign ctl.code  = dec[1:0];
    assign ctl.km1   = k_eff - 5'd1;

    // Cell row: forward data moves up, reverse data moves down
    logic [WIN_W-1:0] fwd_vec, rev_vec, fwd_nvec, rev_nvec;

    genvar g;
    generate
        for (g = 0; g < MAX_K; g++)
        begin : g_cell
            logic [1:0] f_in, r_in;
            if (g == 0)
            begin : g_lo
                assign f_in = ctl.code;
            end
            else
            begin : g_mid
                assign f_in = fwd_vec[2*(g-1) +: 2];
            end
            if (g == MAX_K - 1)
            begin : g_hi
                assign r_in = 2'b00;
            end
            else
            begin : g_nhi
                assign r_in = rev_vec[2*(g+1) +: 2];
            end

            ckx_cell #(.IDX(g)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (accept),
                .ctl      (ctl),
                .fwd_in   (f_in),
                .rev_in   (r_in),
                .fwd_reg  (fwd_vec[2*g +: 2]),
                .rev_reg  (rev_vec[2*g +: 2]),
                .fwd_next (fwd_nvec[2*g +: 2]),
                .rev_next (rev_nvec[2*g +: 2])
            );
        end
    endgenerate

    // Fill count, saturating; restarts on first
    logic [CNT_W-1:0] fill_reg, fill_base, fill_next;

    assign fill_base = ctl.first ? '0 : fill_reg;
    assign fill_next = (fill_base == CNT_SAT) ? fill_base : fill_base + 5'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (accept)
            fill_reg <= fill_next;
    end

    // Canonical pick on the updated windows; a tie goes to reverse
    logic             emit, pick_fwd;
    logic [MER_W-1:0] mer;

    assign emit     = fill_next >= k_eff;
    assign pick_fwd = fwd_nvec < rev_nvec;
    assign mer      = MER_W'(pick_fwd ? fwd_nvec : rev_nvec);

    // Output buffer: {bad_base, from_reverse, pad, canonical_mer}
    logic [DATA_W+1:0] ob_in, ob_out;
    logic              ob_ready;

    assign ob_in = {dec[2], !pick_fwd, 2'b00, mer};

    ckx_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept && emit),
        .in_ready  (ob_ready),
        .in_data   (ob_in),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (ob_out)
    );

    assign s_tready = ob_ready;
    assign m_tdata  = ob_out[DATA_W-1:0];
    assign m_tuser  = ob_out[DATA_W+1:DATA_W];

endmodule

// ----- src/ckx_checker.sv -----
// ----------------------------------------------------------------------------
// ckx_checker
// Port-level checks for the canonical k-mer extractor.
// ----------------------------------------------------------------------------
module ckx_checker
    import ckx_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_we,
    input logic [4:0]        cfg_wdata,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [7:0]        s_tdata,
    input logic [0:0]        s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [1:0]        m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // padding above the mer stays zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[DATA_W-1:MER_W] == 2'b00)
        else $error("tdata padding not zero");

    // a full buffer only frees up when a result leaves
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && !(m_tvalid && m_tready) |=> !s_tready)
        else $error("buffer freed without a result leaving");

    // reset empties the output
    a_rst: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind canonical_kmer_extractor_core ckx_checker u_ckx_checker (.*);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of canonical_kmer_extractor_core. Bases go in one item at
// a time with random gaps while the result side stalls at random. A local
// model of the forward and reverse-complement windows predicts each canonical
// k-mer, and every result item is compared field by field in arrival order.
// The k-mer length is changed between phases, including in mid-sequence.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ckx_pkg::*;

    localparam int RANDOM_ITEMS = 1550;
    localparam int DRAIN_CYCLES = 4;      // idle margin after the result queue empties
    localparam logic [7:0] BASE_CHARS [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};

    typedef struct packed {
        logic [MER_W-1:0] mer;
        logic             from_rev;
        logic             bad;
    } kmer_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b1;
    logic              cfg_we = 1'b0;
    logic [4:0]        cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;
    logic [0:0]        s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [1:0]        m_tuser;

    // model state: register copy and both windows
    logic [4:0]       klen_cfg = KLEN_RESET;
    logic [MER_W-1:0] fwd_win = '0;
    logic [MER_W-1:0] rev_win = '0;
    logic [CNT_W-1:0] fill_cnt = '0;

    kmer_result_t mer_q[$];
    kmer_result_t mer_head;
    int           errors = 0;
    int           items_sent = 0;
    int           ready_hold = 0;
    bit           src_gaps = 1'b1;
    bit           sink_stalls = 1'b1;

    canonical_kmer_extractor_core #(
        .MAX_K(MAX_K_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Roll one base into the model windows; queue the k-mer it yields, if any.
    function automatic void predict_base(input logic [7:0] ch, input logic seq_start);
        logic [1:0]   code;
        logic [1:0]   comp;
        logic         bad;
        int           k;
        logic [63:0]  wmask;
        logic [63:0]  lowmask;
        logic [63:0]  fwd;
        logic [63:0]  rev;
        kmer_result_t res;
        k = (klen_cfg == 5'd0) ? 1 : int'(klen_cfg);
        wmask = (64'd1 << (2 * k)) - 64'd1;
        lowmask = (64'd1 << (2 * k - 2)) - 64'd1;
        bad = 1'b0;
        case (ch)
            "A", "a": code = CODE_A;
            "C", "c": code = CODE_C;
            "G", "g": code = CODE_G;
            "T", "t": code = CODE_T;
            default:
            begin
                code = CODE_A;
                bad = 1'b1;
            end
        endcase
        comp = CODE_T ^ code;
        if (seq_start)
        begin
            fwd_win = '0;
            rev_win = '0;
            fill_cnt = '0;
        end
        fwd = {2'b00, fwd_win};
        rev = {2'b00, rev_win};
        fwd = (((fwd & lowmask) << 2) | {62'd0, code}) & wmask;
        rev = (((rev >> 2) & lowmask) | ({62'd0, comp} << (2 * k - 2))) & wmask;
        fwd_win = fwd[MER_W-1:0];
        rev_win = rev[MER_W-1:0];
        if (fill_cnt != CNT_SAT)
            fill_cnt++;
        if (int'(fill_cnt) >= k)
        begin
            // tie goes to the reverse-complement window
            if (fwd < rev)
            begin
                res.mer = fwd_win;
                res.from_rev = 1'b0;
            end
            else
            begin
                res.mer = rev_win;
                res.from_rev = 1'b1;
            end
            res.bad = bad;
            mer_q.push_back(res);
        end
    endfunction

    // One item; valid stays up across back-to-back items.
    task automatic send_base(input logic [7:0] ch, input logic seq_start);
        int gap;
        gap = 0;
        if (src_gaps && $urandom_range(0, 99) >= 55)
            gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tuser <= seq_start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_base(ch, seq_start);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (mer_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_klen(input logic [4:0] len);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we <= 1'b0;
        klen_cfg = len;
    endtask

    // Reset length 22: too few bases for any k-mer; bad base without a result.
    task automatic test_short_sequence();
        send_base("A", 1'b1);
        send_base("c", 1'b0);
        send_base(8'h00, 1'b0);
        send_base("T", 1'b0);
    endtask

    // Length 0 acts as 1: every base is a k-mer; 0xFF flagged in a result.
    task automatic test_unit_length();
        set_klen(5'd0);
        send_base("G", 1'b1);
        send_base(8'hFF, 1'b0);
        send_base("t", 1'b0);
        send_base("C", 1'b0);
    endtask

    // Palindromic 2-mers (AT, GC) make both windows equal.
    task automatic test_ties();
        set_klen(5'd2);
        send_base("A", 1'b1);
        send_base("T", 1'b0);
        send_base("a", 1'b0);
        send_base("g", 1'b0);
        send_base("c", 1'b0);
    endtask

    // Length changed without a new sequence; windows are masked, not cleared.
    task automatic test_length_change();
        set_klen(5'd3);
        send_base("C", 1'b1);
        send_base("G", 1'b0);
        send_base("T", 1'b0);
        send_base("A", 1'b0);
        set_klen(5'd5);
        send_base("c", 1'b0);
        set_klen(5'd31);
        send_base("A", 1'b0);
        set_klen(5'd4);
        send_base("g", 1'b0);
    endtask

    task automatic send_sequence(input int k);
        int          len;
        logic [7:0]  ch;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, k) : k + $urandom_range(0, 48);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                ch = 8'($urandom_range(0, 255));
            else
                ch = BASE_CHARS[$urandom_range(0, 7)];
            send_base(ch, i == 0);
            // hold the sender until the result side has caught up
            if (i == len / 2 && $urandom_range(0, 11) == 0)
                wait_drained();
        end
    endtask

    task automatic test_random_phases();
        int         start;
        int         phase;
        int         target;
        int         n;
        logic [4:0] len;
        start = items_sent;
        phase = 0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            case (phase)
                0: len = 5'd31;
                1: len = 5'd1;
                2: len = 5'd0;
                3: len = 5'd30;
                default: len = 5'($urandom_range(0, 31));
            endcase
            set_klen(len);
            src_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            target = items_sent + $urandom_range(60, 160);
            while (items_sent < target)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    // raw bytes, with an occasional sequence restart
                    n = $urandom_range(1, 8);
                    repeat (n)
                        send_base(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end
                else
                    send_sequence((len == 5'd0) ? 1 : int'(len));
            end
            phase++;
        end
    endtask

    // result side: random stall stretches
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (sink_stalls && $urandom_range(0, 3) == 0)
                ready_hold <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (mer_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected k-mer item, expected none, actual data %h user %b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                mer_head = mer_q.pop_front();
                if (m_tdata !== {2'b00, mer_head.mer})
                begin
                    errors++;
                    $display("%0t: canonical_mer mismatch, expected %h, actual %h",
                             $time, {2'b00, mer_head.mer}, m_tdata);
                end
                if (m_tuser[0] !== mer_head.from_rev)
                begin
                    errors++;
                    $display("%0t: from_reverse mismatch, expected %b, actual %b",
                             $time, mer_head.from_rev, m_tuser[0]);
                end
                if (m_tuser[1] !== mer_head.bad)
                begin
                    errors++;
                    $display("%0t: bad_base mismatch, expected %b, actual %b",
                             $time, mer_head.bad, m_tuser[1]);
                end
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_short_sequence();
        test_unit_length();
        test_ties();
        test_length_change();
        test_random_phases();
        wait_drained();
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
